// File: hw/rtl/bmbp_pkg.sv
// Package for the bounded MSB-first bit packer: beat structs, packer state,
// register map constants and widths. No dependencies.
`timescale 1ns / 1ps

package bmbp_pkg;

  // Most bytes one block may keep; the kept-byte count is wide enough to reach this value.
  localparam int unsigned MaxBytes = 65536;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned LimitW   = 17;
  localparam int unsigned CmpW     = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned IdxW     = 16;
  localparam int unsigned CodeW    = 16;
  localparam int unsigned NbitsW   = 5;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(65536);

  // Register map, word index taken from the APB address.
  localparam logic RegOutputLimit = 1'b0;

  // Operation codes.
  localparam logic OpPut   = 1'b0;
  localparam logic OpStart = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [NbitsW-1:0] nbits;
    logic [CodeW-1:0]  code_value;
  } in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic [IdxW-1:0] byte_index;
    logic            stored;
    logic            overflow;
    logic            last;
  } out_t;

  typedef struct packed {
    logic [7:0]      partial_byte;
    logic [3:0]      free_bits;
    logic [CntW-1:0] byte_count;
    logic            overflow_flag;
  } state_t;

endpackage

// File: hw/rtl/bmbp_step.sv
// One packing step: from the packer state and one input beat, the next state
// and up to two completed bytes. Purely combinational; depends on bmbp_pkg.
`timescale 1ns / 1ps

module bmbp_step (
  input  bmbp_pkg::state_t            state_i,
  input  bmbp_pkg::in_t               in_i,
  input  logic [bmbp_pkg::CmpW-1:0]   limit_i,
  output bmbp_pkg::state_t            state_o,
  output bmbp_pkg::out_t              res0_o,
  output bmbp_pkg::out_t              res1_o,
  output logic [1:0]                  nres_o
);
  import bmbp_pkg::*;

  logic [4:0]      n;
  logic [CodeW-1:0] mask;
  logic [CodeW-1:0] x;
  logic [4:0]      fb;
  logic [4:0]      m;
  logic [4:0]      m8;
  logic [3:0]      fnew;
  logic [23:0]     sh;
  logic [CodeW-1:0] hi0;
  logic [CodeW-1:0] hi1;
  logic [7:0]      byte0;
  logic [7:0]      byte1;
  logic            kept0;
  logic            kept1;
  logic [CntW-1:0] cnt1;
  logic [CntW-1:0] cnt2;
  logic            ov0;
  logic            ov1;

  always_comb begin
    // Lengths above sixteen are taken as sixteen; stray high code bits are cut.
    n    = (in_i.nbits > 5'd16) ? 5'd16 : in_i.nbits;
    mask = CodeW'((17'd1 << n) - 17'd1);
    x    = in_i.code_value & mask;
    fb   = {1'b0, state_i.free_bits};
    m    = n - fb;
    m8   = m - 5'd8;
    hi0  = x >> m;
    hi1  = x >> m8;
    byte0 = state_i.partial_byte | hi0[7:0];
    byte1 = hi1[7:0];

    // Kept-count bookkeeping for the first and second byte of this beat.
    kept0 = CmpW'(state_i.byte_count) < limit_i;
    cnt1  = state_i.byte_count + CntW'(kept0);
    ov0   = state_i.overflow_flag | ~kept0;
    kept1 = CmpW'(cnt1) < limit_i;
    cnt2  = cnt1 + CntW'(kept1);
    ov1   = ov0 | ~kept1;

    state_o = state_i;
    nres_o  = 2'd0;
    fnew    = state_i.free_bits;
    sh      = '0;

    res0_o.out_byte   = byte0;
    res0_o.byte_index = kept0 ? state_i.byte_count[IdxW-1:0] : '0;
    res0_o.stored     = kept0;
    res0_o.overflow   = ov0;
    res0_o.last       = 1'b1;
    res1_o.out_byte   = byte1;
    res1_o.byte_index = kept1 ? cnt1[IdxW-1:0] : '0;
    res1_o.stored     = kept1;
    res1_o.overflow   = ov1;
    res1_o.last       = 1'b1;

    if (in_i.operation == OpStart) begin
      state_o.partial_byte  = '0;
      state_o.free_bits     = 4'd8;
      state_o.byte_count    = '0;
      state_o.overflow_flag = 1'b0;
    end else if (n < fb) begin
      // The code fits in the partial byte without completing it.
      fnew = state_i.free_bits - n[3:0];
      sh   = {8'd0, x} << fnew;
      state_o.free_bits    = fnew;
      state_o.partial_byte = state_i.partial_byte | sh[7:0];
    end else if (m < 5'd8) begin
      fnew = 4'(5'd8 - m);
      sh   = {8'd0, x} << fnew;
      state_o.free_bits     = fnew;
      state_o.partial_byte  = sh[7:0];
      state_o.byte_count    = cnt1;
      state_o.overflow_flag = ov0;
      nres_o = 2'd1;
    end else begin
      // Two bytes complete; only the second carries the last flag.
      fnew = 4'(5'd16 - m);
      sh   = {8'd0, x} << fnew;
      state_o.free_bits     = fnew;
      state_o.partial_byte  = sh[7:0];
      state_o.byte_count    = cnt2;
      state_o.overflow_flag = ov1;
      res0_o.last = 1'b0;
      nres_o = 2'd2;
    end
  end

endmodule

// File: hw/rtl/bounded_msb_first_bit_packer.sv
// Top level of the bounded MSB-first bit packer: handshakes, packer state,
// the two-slot result buffer and the APB register. Depends on bmbp_pkg, bmbp_step.
`timescale 1ns / 1ps

// The packer appends codes of 0 to 16 bits, most significant bit first, to a
// partial byte and sends out every byte as it fills, one byte per output beat.
// Each input beat that completes bytes yields one or two output beats, the
// final one flagged last; a start beat or a zero-length code yields none. A
// completed byte is kept and numbered while the kept count is below the
// smaller of output_limit and the block maximum; after that, bytes are
// reported as dropped with index zero and the sticky overflow flag is set
// until the next start beat. The packer state is updated in the cycle an input
// beat is accepted, and its results land in a two-entry output buffer. An
// input beat is taken whenever the buffer will be empty after the current
// cycle, so a beat completing at most one byte passes at one per cycle while
// the output is ready; after a beat completing two bytes, the next waits
// until the second byte leaves. Results appear in the cycle after acceptance.
// output_limit sits at APB address 0 and must be written only while idle.
module bounded_msb_first_bit_packer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bmbp_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output bmbp_pkg::out_t       out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bmbp_pkg::*;

  state_t            state_q;
  state_t            state_d;
  state_t            step_state;
  logic [LimitW-1:0] limit_q;
  logic [CmpW-1:0]   limit_eff;
  out_t              res0;
  out_t              res1;
  logic [1:0]        nres;
  out_t              slot0_q;
  out_t              slot0_d;
  out_t              slot1_q;
  out_t              slot1_d;
  logic              v0_q;
  logic              v0_d;
  logic              v1_q;
  logic              v1_d;
  logic              pop;
  logic              accept;
  logic              cfg_write;

  // Limit in force is the smaller of the register and the block maximum.
  assign limit_eff = (CmpW'(limit_q) < CmpW'(MaxBytes)) ? CmpW'(limit_q) : CmpW'(MaxBytes);

  bmbp_step u_step (
    .state_i (state_q),
    .in_i    (in_data_i),
    .limit_i (limit_eff),
    .state_o (step_state),
    .res0_o  (res0),
    .res1_o  (res1),
    .nres_o  (nres)
  );

  assign pop         = v0_q & out_ready_i;
  // Take a new beat only when the buffer drains completely this cycle.
  assign in_ready_o  = ~v0_q | (out_ready_i & ~v1_q);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = v0_q;
  assign out_data_o  = slot0_q;

  always_comb begin
    state_d = accept ? step_state : state_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    if (accept) begin
      // Buffer is empty after this cycle, so fresh results fill from the head.
      slot0_d = res0;
      slot1_d = res1;
      v0_d    = (nres != 2'd0);
      v1_d    = (nres == 2'd2);
    end else if (pop) begin
      slot0_d = slot1_q;
      v0_d    = v1_q;
      v1_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.partial_byte  <= '0;
      state_q.free_bits     <= 4'd8;
      state_q.byte_count    <= '0;
      state_q.overflow_flag <= 1'b0;
      v0_q                  <= 1'b0;
      v1_q                  <= 1'b0;
    end else begin
      state_q <= state_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  // APB register access; the port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == RegOutputLimit);
  assign prdata    = (paddr[2] == RegOutputLimit) ? {{(32 - LimitW){1'b0}}, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_write) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

endmodule
